// ----- sv/rbht_pkg.sv -----
`timescale 1ns / 1ps

package rbht_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ADDR_BITS   = 48;
  localparam int GEN_BITS    = 32;
  localparam int REF_BITS    = 16;
  localparam int HANDLE_BITS = 64;

  // Beat layout on both streams.
  localparam int IN_DATA_BITS  = 184;
  localparam int OUT_DATA_BITS = 136;

  // Request kinds carried in the input tuser.
  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_DEREGISTER = 2'd1,
    REQ_RESTORE    = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_t;

  // Result status codes carried in the output tuser.
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_INVALID     = 2'd1,
    STAT_CREATE_FAIL = 2'd2,
    STAT_FULL        = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE_SCAN,
    ST_LOOKUP,
    ST_DEREG,
    ST_OUT
  } state_t;

endpackage

// ----- sv/refcounted_bridge_handle_table.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  request: tuser = kind, tdata = operands
// m_*       out        m_tvalid / m_tready  result: tuser = status, tdata = handles
//
// One request is taken at a time. Restore and clear load the result directly; deregister
// passes through the handle check; register may run the free-slot search, then the lookup.
// Both walk the slots one per cycle through a single shared slot read port; the lookup
// also uses the single address comparator.
// Reset empties the table and zeroes the generation.
// A result waits in the output register until m_tready; no request is taken meanwhile.

module refcounted_bridge_handle_table
  import rbht_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // [47:0] phys_addr, [48] already_exists, [49] create_ok, [113:50] fw_handle,
  // [177:114] client_handle, [183:178] zero
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // [1:0] req_type
  input  logic [1:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // [63:0] handle_out, [64] release_valid, [128:65] release_handle, [135:129] zero
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // [1:0] status
  output logic [1:0]               m_tuser
);

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_DEPTH - 1);
  localparam logic [REF_BITS-1:0] REF_MAX  = '1;

  // Slot storage.
  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [ADDR_BITS-1:0]   slot_addr      [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0] slot_fw_handle [TABLE_DEPTH];
  logic [REF_BITS-1:0]    slot_refcount  [TABLE_DEPTH];
  logic [GEN_BITS-1:0]    generation;

  // Sequencer and latched request.
  state_t                 state, state_next;
  logic [IDX_BITS-1:0]    cnt;
  logic [ADDR_BITS-1:0]   req_addr;
  logic [HANDLE_BITS-1:0] req_fw;
  logic [HANDLE_BITS-1:0] req_client;

  // Result register.
  logic [1:0]             res_status;
  logic [HANDLE_BITS-1:0] res_handle;
  logic                   res_rel;
  logic [HANDLE_BITS-1:0] res_rel_handle;

  // Input beat fields.
  logic                   in_accept;
  req_t                   in_req;
  logic                   in_exists;
  logic                   in_create;

  assign in_accept = s_tvalid && s_tready;
  assign in_req    = req_t'(s_tuser);
  assign in_exists = s_tdata[48];
  assign in_create = s_tdata[49];

  // Single slot read port, steered by the deregister index or the scan counter.
  logic [IDX_BITS-1:0]    rd_idx;
  logic                   rd_valid;
  logic [REF_BITS-1:0]    rd_ref;
  logic [REF_BITS-1:0]    rd_ref_dec;
  logic                   scan_last;
  logic                   addr_hit;
  logic                   dereg_ok;

  assign rd_idx     = (state == ST_DEREG) ? req_client[IDX_BITS-1:0] : cnt;
  assign rd_valid   = slot_valid[rd_idx];
  assign rd_ref     = slot_refcount[rd_idx];
  assign rd_ref_dec = rd_ref - REF_BITS'(1);
  assign scan_last  = (cnt == LAST_IDX);

  // The address comparator: stored address against the request address.
  assign addr_hit = rd_valid && (slot_addr[rd_idx] == req_addr);

  // Handle check for deregister: generation, index range, occupied slot, nonzero count.
  assign dereg_ok = (req_client[HANDLE_BITS-1:GEN_BITS] == generation) &&
                    (req_client[GEN_BITS-1:0] < GEN_BITS'(TABLE_DEPTH)) &&
                    rd_valid && (rd_ref != '0);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_req)
            REQ_REGISTER: begin
              if (in_exists) begin
                state_next = ST_LOOKUP;
              end else if (in_create) begin
                state_next = ST_FREE_SCAN;
              end else begin
                state_next = ST_OUT;
              end
            end
            REQ_DEREGISTER: state_next = ST_DEREG;
            default:        state_next = ST_OUT;
          endcase
        end
      end
      ST_FREE_SCAN: begin
        if (!rd_valid) begin
          state_next = ST_LOOKUP;
        end else if (scan_last) begin
          state_next = ST_OUT;
        end
      end
      ST_LOOKUP: begin
        if (addr_hit || scan_last) begin
          state_next = ST_OUT;
        end
      end
      ST_DEREG: state_next = ST_OUT;
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  logic                   cnt_clr;
  logic                   cnt_inc;
  logic                   wr_new;
  logic                   ref_inc;
  logic                   ref_dec;
  logic                   slot_free;
  logic                   clear_all;
  logic                   gen_inc;
  logic                   res_load;
  logic [1:0]             res_status_next;
  logic [HANDLE_BITS-1:0] res_handle_next;
  logic                   res_rel_next;
  logic [HANDLE_BITS-1:0] res_rel_handle_next;

  always_comb begin
    cnt_clr             = 1'b0;
    cnt_inc             = 1'b0;
    wr_new              = 1'b0;
    ref_inc             = 1'b0;
    ref_dec             = 1'b0;
    slot_free           = 1'b0;
    clear_all           = 1'b0;
    gen_inc             = 1'b0;
    res_load            = 1'b0;
    res_status_next     = STAT_OK;
    res_handle_next     = '0;
    res_rel_next        = 1'b0;
    res_rel_handle_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          cnt_clr = 1'b1;
          unique case (in_req)
            REQ_REGISTER: begin
              if (!in_exists && !in_create) begin
                res_load        = 1'b1;
                res_status_next = STAT_CREATE_FAIL;
              end
            end
            REQ_DEREGISTER: begin
            end
            REQ_RESTORE: begin
              gen_inc   = 1'b1;
              clear_all = 1'b1;
              res_load  = 1'b1;
            end
            default: begin
              clear_all = 1'b1;
              res_load  = 1'b1;
            end
          endcase
        end
      end
      ST_FREE_SCAN: begin
        if (!rd_valid) begin
          wr_new  = 1'b1;
          cnt_clr = 1'b1;
        end else if (scan_last) begin
          res_load            = 1'b1;
          res_status_next     = STAT_FULL;
          res_rel_next        = 1'b1;
          res_rel_handle_next = req_fw;
        end else begin
          cnt_inc = 1'b1;
        end
      end
      ST_LOOKUP: begin
        if (addr_hit) begin
          ref_inc         = (rd_ref != REF_MAX);
          res_load        = 1'b1;
          res_handle_next = {generation, GEN_BITS'(cnt)};
        end else if (scan_last) begin
          res_load        = 1'b1;
          res_status_next = STAT_INVALID;
        end else begin
          cnt_inc = 1'b1;
        end
      end
      ST_DEREG: begin
        res_load = 1'b1;
        if (dereg_ok) begin
          ref_dec = 1'b1;
          if (rd_ref_dec == '0) begin
            slot_free           = 1'b1;
            res_rel_next        = 1'b1;
            res_rel_handle_next = slot_fw_handle[rd_idx];
          end
        end else begin
          res_status_next = STAT_INVALID;
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      generation <= '0;
      slot_valid <= '0;
    end else begin
      state <= state_next;
      if (cnt_clr) begin
        cnt <= '0;
      end else if (cnt_inc) begin
        cnt <= cnt + IDX_BITS'(1);
      end
      if (gen_inc) begin
        generation <= generation + GEN_BITS'(1);
      end
      if (clear_all) begin
        slot_valid <= '0;
      end else if (wr_new) begin
        slot_valid[rd_idx] <= 1'b1;
      end else if (slot_free) begin
        slot_valid[rd_idx] <= 1'b0;
      end
    end
  end

  // Slot payload and latched request.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_addr   <= s_tdata[ADDR_BITS-1:0];
      req_fw     <= s_tdata[113:50];
      req_client <= s_tdata[177:114];
    end
    if (wr_new) begin
      slot_addr[rd_idx]      <= req_addr;
      slot_fw_handle[rd_idx] <= req_fw;
      slot_refcount[rd_idx]  <= '0;
    end else if (ref_inc) begin
      slot_refcount[rd_idx] <= rd_ref + REF_BITS'(1);
    end else if (ref_dec) begin
      slot_refcount[rd_idx] <= rd_ref_dec;
    end
    if (res_load) begin
      res_status     <= res_status_next;
      res_handle     <= res_handle_next;
      res_rel        <= res_rel_next;
      res_rel_handle <= res_rel_handle_next;
    end
  end

  // Stream ports.
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tuser  = res_status;
  assign m_tdata  = {7'd0, res_rel_handle, res_rel, res_handle};

  // A restore advances the generation by exactly one.
  a_restore_gen: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_req == REQ_RESTORE)) |=> (generation == $past(generation) + 32'd1))
    else $error("restore did not advance the generation by one");

  // Restore and clear leave the table empty.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (in_accept && ((in_req == REQ_RESTORE) || (in_req == REQ_CLEAR))) |=> (slot_valid == '0))
    else $error("table not empty after restore or clear");

  // A release comes only with a freed slot or a full table.
  a_release_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_rel) |-> ((res_status == STAT_OK) || (res_status == STAT_FULL)))
    else $error("release requested with a failing status");

  // A handle is returned only on success.
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res_status != STAT_OK)) |-> (res_handle == '0))
    else $error("nonzero handle on a failing result");

endmodule
